### rtl/dpt_pkg.sv
// Shared types and constants of the dedup pattern table.
package dpt_pkg;

  localparam int unsigned MaxSteps   = 32;
  localparam int unsigned MaxEntries = 32;

  localparam int unsigned StepW = MaxSteps;
  localparam int unsigned LenW  = $clog2(MaxSteps + 1);
  localparam int unsigned IdW   = $clog2(MaxEntries + 1);
  localparam int unsigned IdxW  = $clog2(MaxEntries);
  localparam int unsigned CntW  = $clog2(MaxEntries + 1);

  typedef enum logic [1:0] {
    OP_ADD_OR_FIND   = 2'd0,
    OP_FIND_BY_ID    = 2'd1,
    OP_FIND_EQUIV    = 2'd2,
    OP_READ_AT_INDEX = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_INVALID   = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // Search request traveling down the cell chain, with the first hit it picked up.
  typedef struct packed {
    logic              active;
    opcode_e           op;
    logic [StepW-1:0]  bits;
    logic [LenW-1:0]   len;
    logic              len_ok;
    logic [IdW-1:0]    id;
    logic [IdxW-1:0]   idx;
    logic              hit;
    logic [IdxW-1:0]   hit_idx;
    logic [IdW-1:0]    hit_id;
    logic [LenW-1:0]   hit_len;
    logic [StepW-1:0]  hit_steps;
  } token_t;

  // Entry write broadcast to all cells.
  typedef struct packed {
    logic              en;
    logic [IdxW-1:0]   idx;
    logic [IdW-1:0]    id;
    logic [LenW-1:0]   len;
    logic [StepW-1:0]  steps;
  } wr_t;

endpackage

### rtl/dpt_cell.sv
// One table entry: holds a pattern and checks the passing request against it.
module dpt_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dpt_pkg::wr_t    wr_i,
  input  dpt_pkg::token_t tok_i,
  output dpt_pkg::token_t tok_o
);

  localparam logic [dpt_pkg::IdxW-1:0] CellIdx = dpt_pkg::IdxW'(CELL_IDX);

  logic                       valid_q;
  logic [dpt_pkg::IdW-1:0]    id_q;
  logic [dpt_pkg::LenW-1:0]   len_q;
  logic [dpt_pkg::StepW-1:0]  steps_q;
  logic                       match;
  logic                       wr_here;
  dpt_pkg::token_t            tok_d;
  dpt_pkg::token_t            tok_q;

  assign wr_here = wr_i.en && (wr_i.idx == CellIdx);

  always_comb begin
    match = 1'b0;
    unique case (tok_i.op)
      dpt_pkg::OP_ADD_OR_FIND, dpt_pkg::OP_FIND_EQUIV: begin
        // stored and offered bits are both cleared above the length
        match = tok_i.len_ok && (len_q == tok_i.len) && (steps_q == tok_i.bits);
      end
      dpt_pkg::OP_FIND_BY_ID:    match = (id_q == tok_i.id);
      dpt_pkg::OP_READ_AT_INDEX: match = (tok_i.idx == CellIdx);
      default:                   match = 1'b0;
    endcase
  end

  always_comb begin
    tok_d = tok_i;
    // keep the first hit, closest to the head of the table
    if (valid_q && !tok_i.hit && match) begin
      tok_d.hit       = 1'b1;
      tok_d.hit_idx   = CellIdx;
      tok_d.hit_id    = id_q;
      tok_d.hit_len   = len_q;
      tok_d.hit_steps = steps_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_here) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_here) begin
      id_q    <= wr_i.id;
      len_q   <= wr_i.len;
      steps_q <= wr_i.steps;
    end
  end

  assign tok_o = tok_q;

endmodule

### rtl/dedup_pattern_table_core.sv
// Top level of the dedup pattern table: request issue, cell chain and result stage.
//
// Request channel (in_valid_i / in_stall_o) takes opcode, step bits, length,
// id and index. Result channel (out_valid_o / out_stall_i) returns one result
// per request: status, entry id, index, stored steps, stored length and the
// entry count after the operation.
// Each request enters a chain of 32 entry cells and moves one cell per cycle;
// every cell compares it against its own entry and the first hit is carried
// to the end. The request is registered, passes the cell registers and is
// captured in the result stage, then loaded into the output register; the
// next request is taken only once that load has happened.
// add_or_find appends a new entry into the next free cell when the pattern is
// not present, the length is valid and the table is not full; since entries
// are never removed, the lowest free id is always the entry count plus one.
// Reset empties the table and drops any request in flight. While the
// receiver stalls, the result is held in the output register; a finished
// search then waits in the result stage and no new request is taken.
module dedup_pattern_table_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 opcode_i,
  input  logic [dpt_pkg::StepW-1:0]  step_bits_i,
  input  logic [dpt_pkg::LenW-1:0]   pattern_length_i,
  input  logic [dpt_pkg::IdW-1:0]    entry_id_i,
  input  logic [dpt_pkg::IdxW-1:0]   entry_index_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 status_o,
  output logic [dpt_pkg::IdW-1:0]    result_id_o,
  output logic [dpt_pkg::IdxW-1:0]   result_index_o,
  output logic [dpt_pkg::StepW-1:0]  result_steps_o,
  output logic [dpt_pkg::LenW-1:0]   result_length_o,
  output logic [dpt_pkg::CntW-1:0]   entry_count_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_e;

  state_e                     state_q, state_d;
  dpt_pkg::token_t            tok_q, tok_d;
  dpt_pkg::token_t            res_q, res_d;
  dpt_pkg::token_t            chain [0:dpt_pkg::MaxEntries];
  dpt_pkg::wr_t               wr;
  logic [dpt_pkg::CntW-1:0]   count_q, count_d;
  logic                       accept;
  logic                       load;
  logic                       full;
  logic                       insert;

  logic                       out_valid_q, out_valid_d;
  dpt_pkg::status_e           status_q, status_d;
  logic [dpt_pkg::IdW-1:0]    rid_q, rid_d;
  logic [dpt_pkg::IdxW-1:0]   ridx_q, ridx_d;
  logic [dpt_pkg::StepW-1:0]  rsteps_q, rsteps_d;
  logic [dpt_pkg::LenW-1:0]   rlen_q, rlen_d;
  logic [dpt_pkg::CntW-1:0]   rcnt_q, rcnt_d;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Build the request: clear offered bits at and above the length.
  always_comb begin
    tok_d        = '0;
    tok_d.active = accept;
    tok_d.op     = dpt_pkg::opcode_e'(opcode_i);
    for (int b = 0; b < dpt_pkg::StepW; b++) begin
      tok_d.bits[b] = step_bits_i[b] && (dpt_pkg::LenW'(b) < pattern_length_i);
    end
    tok_d.len    = pattern_length_i;
    tok_d.len_ok = (pattern_length_i != '0) &&
                   (pattern_length_i <= dpt_pkg::LenW'(dpt_pkg::MaxSteps));
    tok_d.id     = entry_id_i;
    tok_d.idx    = entry_index_i;
  end

  assign chain[0] = tok_q;

  for (genvar k = 0; k < dpt_pkg::MaxEntries; k++) begin : g_cell
    dpt_cell #(
      .CELL_IDX(k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .wr_i  (wr),
      .tok_i (chain[k]),
      .tok_o (chain[k+1])
    );
  end

  assign full   = (count_q >= dpt_pkg::CntW'(dpt_pkg::MaxEntries));
  assign load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign insert = (res_q.op == dpt_pkg::OP_ADD_OR_FIND) && !res_q.hit &&
                  res_q.len_ok && !full;

  always_comb begin
    wr       = '0;
    wr.en    = load && insert;
    wr.idx   = count_q[dpt_pkg::IdxW-1:0];
    wr.id    = dpt_pkg::IdW'(count_q + 1'b1);
    wr.len   = res_q.len;
    wr.steps = res_q.bits;
  end

  // Next state, result capture and output register.
  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    rid_d       = rid_q;
    ridx_d      = ridx_q;
    rsteps_d    = rsteps_q;
    rlen_d      = rlen_q;
    rcnt_d      = rcnt_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // grab the request as it leaves the last cell
        if (chain[dpt_pkg::MaxEntries].active) begin
          res_d   = chain[dpt_pkg::MaxEntries];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load) begin
          out_valid_d = 1'b1;
          rid_d       = '0;
          ridx_d      = '0;
          rsteps_d    = '0;
          rlen_d      = '0;
          priority if (res_q.hit) begin
            status_d = dpt_pkg::ST_FOUND;
            rid_d    = res_q.hit_id;
            ridx_d   = res_q.hit_idx;
            rsteps_d = res_q.hit_steps;
            rlen_d   = res_q.hit_len;
          end else if (res_q.op != dpt_pkg::OP_ADD_OR_FIND) begin
            status_d = dpt_pkg::ST_NOT_FOUND;
          end else if (!res_q.len_ok) begin
            status_d = dpt_pkg::ST_INVALID;
          end else if (full) begin
            status_d = dpt_pkg::ST_FULL;
          end else begin
            status_d = dpt_pkg::ST_INSERTED;
            rid_d    = wr.id;
            ridx_d   = wr.idx;
            rsteps_d = res_q.bits;
            rlen_d   = res_q.len;
            count_d  = count_q + 1'b1;
          end
          rcnt_d  = count_d;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tok_q       <= '0;
      res_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= dpt_pkg::ST_NOT_FOUND;
      rid_q       <= '0;
      ridx_q      <= '0;
      rsteps_q    <= '0;
      rlen_q      <= '0;
      rcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      tok_q       <= tok_d;
      res_q       <= res_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      rid_q       <= rid_d;
      ridx_q      <= ridx_d;
      rsteps_q    <= rsteps_d;
      rlen_q      <= rlen_d;
      rcnt_q      <= rcnt_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign result_id_o     = rid_q;
  assign result_index_o  = ridx_q;
  assign result_steps_o  = rsteps_q;
  assign result_length_o = rlen_q;
  assign entry_count_o   = rcnt_q;

endmodule

### rtl/dpt_checker.sv
// Port-level checks of the dedup pattern table, bound to the top level.
module dpt_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_o,
  input  logic                       out_valid_o,
  input  logic                       out_stall_i,
  input  logic [2:0]                 status_o,
  input  logic [dpt_pkg::IdW-1:0]    result_id_o,
  input  logic [dpt_pkg::IdxW-1:0]   result_index_o,
  input  logic [dpt_pkg::StepW-1:0]  result_steps_o,
  input  logic [dpt_pkg::LenW-1:0]   result_length_o,
  input  logic [dpt_pkg::CntW-1:0]   entry_count_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(result_id_o) && $stable(result_steps_o) && $stable(entry_count_o))
    else $error("stalled result changed");

  // one request at a time
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while another is in flight");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= dpt_pkg::CntW'(dpt_pkg::MaxEntries))
    else $error("entry count beyond table size");

  // a new entry lands at the end of the table under the next id
  a_insert_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == dpt_pkg::ST_INSERTED |->
    result_id_o == entry_count_o &&
    dpt_pkg::CntW'(result_index_o) == entry_count_o - 1'b1)
    else $error("inserted entry at wrong place");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != dpt_pkg::ST_FOUND && status_o != dpt_pkg::ST_INSERTED |->
    result_id_o == '0 && result_index_o == '0 && result_steps_o == '0 &&
    result_length_o == '0)
    else $error("entry fields set without an entry");

endmodule

bind dedup_pattern_table_core dpt_checker u_dpt_checker (.*);

### dv/tb_dedup_pattern_table_core.sv
// Self-checking testbench for dedup_pattern_table_core: directed and random requests, table tracker.
module tb_dedup_pattern_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 1930;
  localparam int unsigned PassLatency = 35;
  localparam longint      SimLimitNs  = 40_000_000;

  typedef struct {
    logic [2:0]                status;
    logic [dpt_pkg::IdW-1:0]   id;
    logic [dpt_pkg::IdxW-1:0]  index;
    logic [dpt_pkg::StepW-1:0] steps;
    logic [dpt_pkg::LenW-1:0]  length;
    logic [dpt_pkg::CntW-1:0]  count;
  } table_result_t;

  // Mirror of the pattern table plus the results it still owes.
  class pattern_table_tracker;
    int unsigned                    count;
    logic [dpt_pkg::IdW-1:0]        ids   [dpt_pkg::MaxEntries];
    logic [dpt_pkg::LenW-1:0]       lens  [dpt_pkg::MaxEntries];
    logic [dpt_pkg::StepW-1:0]      steps [dpt_pkg::MaxEntries];
    logic [dpt_pkg::MaxEntries-1:0] used_ids;
    table_result_t                  pending [$];
    int unsigned                    errors;
    int unsigned                    checked;
    int unsigned                    status_seen [5];

    function new();
      count    = 0;
      used_ids = '0;
      errors   = 0;
      checked  = 0;
      foreach (status_seen[s]) status_seen[s] = 0;
    endfunction

    static function logic [dpt_pkg::StepW-1:0] low_mask(logic [dpt_pkg::LenW-1:0] len);
      logic [63:0] m;
      m = (64'd1 << len) - 64'd1;
      return m[dpt_pkg::StepW-1:0];
    endfunction

    static function bit len_ok(logic [dpt_pkg::LenW-1:0] len);
      return len >= 1 && len <= dpt_pkg::MaxSteps;
    endfunction

    // First entry with equal length and equal bits below that length, or -1.
    function int match_position(logic [dpt_pkg::StepW-1:0] bits,
                                logic [dpt_pkg::LenW-1:0] len);
      logic [dpt_pkg::StepW-1:0] m;
      m = low_mask(len);
      if (!len_ok(len)) return -1;
      for (int i = 0; i < count; i++) begin
        if (lens[i] == len && ((steps[i] ^ bits) & m) == '0) return i;
      end
      return -1;
    endfunction

    function table_result_t make_result(dpt_pkg::status_e s, int pos);
      table_result_t r;
      r.status = s;
      if (pos >= 0 && pos < count) begin
        r.id     = ids[pos];
        r.index  = pos[dpt_pkg::IdxW-1:0];
        r.steps  = steps[pos];
        r.length = lens[pos];
      end else begin
        r.id     = '0;
        r.index  = '0;
        r.steps  = '0;
        r.length = '0;
      end
      r.count = count[dpt_pkg::CntW-1:0];
      return r;
    endfunction

    function void note_request(dpt_pkg::opcode_e op, logic [dpt_pkg::StepW-1:0] bits,
                               logic [dpt_pkg::LenW-1:0] len, logic [dpt_pkg::IdW-1:0] id,
                               logic [dpt_pkg::IdxW-1:0] idx);
      int            pos;
      int unsigned   fresh_id;
      table_result_t r;
      pos = -1;
      unique case (op)
        dpt_pkg::OP_ADD_OR_FIND: begin
          pos = match_position(bits, len);
          if (pos >= 0) begin
            r = make_result(dpt_pkg::ST_FOUND, pos);
          end else if (!len_ok(len)) begin
            r = make_result(dpt_pkg::ST_INVALID, -1);
          end else if (count >= dpt_pkg::MaxEntries) begin
            r = make_result(dpt_pkg::ST_FULL, -1);
          end else begin
            fresh_id = 0;
            for (int v = int'(dpt_pkg::MaxEntries); v >= 1; v--) begin
              if (!used_ids[v-1]) fresh_id = v;
            end
            if (fresh_id == 0) begin
              r = make_result(dpt_pkg::ST_FULL, -1);
            end else begin
              ids[count]            = fresh_id[dpt_pkg::IdW-1:0];
              lens[count]           = len;
              steps[count]          = bits & low_mask(len);
              used_ids[fresh_id-1]  = 1'b1;
              count++;
              r = make_result(dpt_pkg::ST_INSERTED, int'(count) - 1);
            end
          end
        end
        dpt_pkg::OP_FIND_BY_ID: begin
          if (id != 0) begin
            for (int i = int'(count) - 1; i >= 0; i--) begin
              if (ids[i] == id) pos = i;
            end
          end
          r = make_result(pos >= 0 ? dpt_pkg::ST_FOUND : dpt_pkg::ST_NOT_FOUND, pos);
        end
        dpt_pkg::OP_FIND_EQUIV: begin
          pos = match_position(bits, len);
          r = make_result(pos >= 0 ? dpt_pkg::ST_FOUND : dpt_pkg::ST_NOT_FOUND, pos);
        end
        default: begin
          if (idx < count) r = make_result(dpt_pkg::ST_FOUND, int'(idx));
          else r = make_result(dpt_pkg::ST_NOT_FOUND, -1);
        end
      endcase
      status_seen[r.status]++;
      pending.push_back(r);
    endfunction

    function void check_field(string name, logic [dpt_pkg::StepW-1:0] want,
                              logic [dpt_pkg::StepW-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (pending.size() == 0) begin
        $error("result with no request outstanding, status %0d", got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      check_field("status", dpt_pkg::StepW'(want.status), dpt_pkg::StepW'(got.status));
      check_field("result_id", dpt_pkg::StepW'(want.id), dpt_pkg::StepW'(got.id));
      check_field("result_index", dpt_pkg::StepW'(want.index), dpt_pkg::StepW'(got.index));
      check_field("result_steps", want.steps, got.steps);
      check_field("result_length", dpt_pkg::StepW'(want.length),
                  dpt_pkg::StepW'(got.length));
      check_field("entry_count", dpt_pkg::StepW'(want.count), dpt_pkg::StepW'(got.count));
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n          = 1'b0;
  logic                       in_valid       = 1'b0;
  logic                       in_stall;
  logic [1:0]                 opcode         = '0;
  logic [dpt_pkg::StepW-1:0]  step_bits      = '0;
  logic [dpt_pkg::LenW-1:0]   pattern_length = '0;
  logic [dpt_pkg::IdW-1:0]    entry_id       = '0;
  logic [dpt_pkg::IdxW-1:0]   entry_index    = '0;
  logic                       out_valid;
  logic                       out_stall      = 1'b0;
  logic [2:0]                 status;
  logic [dpt_pkg::IdW-1:0]    result_id;
  logic [dpt_pkg::IdxW-1:0]   result_index;
  logic [dpt_pkg::StepW-1:0]  result_steps;
  logic [dpt_pkg::LenW-1:0]   result_length;
  logic [dpt_pkg::CntW-1:0]   entry_count;

  pattern_table_tracker tracker = new();

  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  dedup_pattern_table_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .opcode_i         (opcode),
    .step_bits_i      (step_bits),
    .pattern_length_i (pattern_length),
    .entry_id_i       (entry_id),
    .entry_index_i    (entry_index),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .result_id_o      (result_id),
    .result_index_o   (result_index),
    .result_steps_o   (result_steps),
    .result_length_o  (result_length),
    .entry_count_o    (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #SimLimitNs;
    $display("[dedup_pattern_table_core] ERROR");
    $finish;
  end

  // Offer one request, hold it until taken, then maybe idle between bursts.
  task automatic send_request(dpt_pkg::opcode_e op, logic [dpt_pkg::StepW-1:0] bits,
                              logic [dpt_pkg::LenW-1:0] len, logic [dpt_pkg::IdW-1:0] id,
                              logic [dpt_pkg::IdxW-1:0] idx);
    int unsigned gap;
    in_valid       <= 1'b1;
    opcode         <= op;
    step_bits      <= bits;
    pattern_length <= len;
    entry_id       <= id;
    entry_index    <= idx;
    do @(posedge clk); while (in_stall);
    tracker.note_request(op, bits, len, id, idx);
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        burst_left = 40;
        gap        = 0;
      end else begin
        burst_left = $urandom_range(0, 10);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
      end
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Drop the request line so nothing already taken is offered again, then wait until every result is checked.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  // Check results and drive the stall pattern.
  always @(posedge clk) begin : result_monitor
    table_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.status = status;
      got.id     = result_id;
      got.index  = result_index;
      got.steps  = result_steps;
      got.length = result_length;
      got.count  = entry_count;
      tracker.check_result(got);
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    unique case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= ((stall_left % 48) < 30);
    endcase
  end

  initial begin : stimulus
    dpt_pkg::opcode_e          op;
    logic [dpt_pkg::StepW-1:0] bits;
    logic [dpt_pkg::LenW-1:0]  len;
    logic [dpt_pkg::IdW-1:0]   id;
    logic [dpt_pkg::IdxW-1:0]  idx;
    int unsigned               pick;
    int unsigned               k;
    int unsigned               b;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table
    send_request(dpt_pkg::OP_READ_AT_INDEX, '0, '0, '0, 5'd0);
    send_request(dpt_pkg::OP_FIND_BY_ID, '0, '0, 6'd0, '0);
    send_request(dpt_pkg::OP_FIND_BY_ID, '1, '1, 6'd63, '1);
    send_request(dpt_pkg::OP_FIND_EQUIV, 32'h1234_5678, 6'd8, '0, '0);
    // zero and overlong lengths
    send_request(dpt_pkg::OP_ADD_OR_FIND, '1, 6'd0, '0, '0);
    send_request(dpt_pkg::OP_ADD_OR_FIND, '1, 6'd33, '0, '0);
    send_request(dpt_pkg::OP_ADD_OR_FIND, '0, 6'd63, '0, '0);
    // full width pattern, then its duplicate
    send_request(dpt_pkg::OP_ADD_OR_FIND, '1, 6'd32, '0, '0);
    send_request(dpt_pkg::OP_ADD_OR_FIND, '1, 6'd32, '1, '1);
    // extra offered bits are ignored and not stored
    send_request(dpt_pkg::OP_ADD_OR_FIND, '1, 6'd1, '0, '0);
    send_request(dpt_pkg::OP_ADD_OR_FIND, 32'h0000_0001, 6'd1, '0, '0);
    send_request(dpt_pkg::OP_FIND_EQUIV, 32'hFFFF_FFFD, 6'd1, '0, '0);
    send_request(dpt_pkg::OP_ADD_OR_FIND, '0, 6'd32, '0, '0);
    send_request(dpt_pkg::OP_ADD_OR_FIND, 32'hA5A5_A5A5, 6'd16, '0, '0);
    send_request(dpt_pkg::OP_FIND_EQUIV, 32'h0000_A5A5, 6'd16, '0, '0);
    send_request(dpt_pkg::OP_FIND_EQUIV, '1, 6'd32, '0, '0);
    send_request(dpt_pkg::OP_FIND_EQUIV, '1, 6'd0, '0, '0);
    send_request(dpt_pkg::OP_FIND_EQUIV, '1, 6'd40, '0, '0);
    send_request(dpt_pkg::OP_FIND_BY_ID, '0, '0, 6'd1, '0);
    send_request(dpt_pkg::OP_FIND_BY_ID, '0, '0, 6'd4, '0);
    send_request(dpt_pkg::OP_FIND_BY_ID, '0, '0, 6'd32, '0);
    send_request(dpt_pkg::OP_READ_AT_INDEX, '0, '0, '0, 5'd3);
    send_request(dpt_pkg::OP_READ_AT_INDEX, '0, '0, '0, 5'd4);
    send_request(dpt_pkg::OP_READ_AT_INDEX, '0, '0, '0, 5'd31);

    // hold off until the block has answered everything
    wait_for_results();

    for (int n = 0; n < RandomItems; n++) begin
      op   = dpt_pkg::opcode_e'($urandom_range(0, 3));
      bits = $urandom();
      len  = dpt_pkg::LenW'($urandom_range(1, dpt_pkg::MaxSteps));
      id   = dpt_pkg::IdW'($urandom_range(0, 63));
      idx  = dpt_pkg::IdxW'($urandom_range(0, 31));
      pick = $urandom_range(0, 99);
      unique case (op)
        dpt_pkg::OP_ADD_OR_FIND, dpt_pkg::OP_FIND_EQUIV: begin
          if (pick >= 95 || tracker.count == 0) begin
            if ($urandom_range(0, 1) == 0) len = dpt_pkg::LenW'($urandom_range(1, 6));
          end else if (pick >= 85) begin
            len = ($urandom_range(0, 2) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
          end else begin
            // reuse a stored pattern with random bits above its length
            k    = $urandom_range(0, tracker.count - 1);
            len  = tracker.lens[k];
            bits = tracker.steps[k] | (bits & ~tracker.low_mask(len));
            if (pick < 5) begin
              b       = $urandom_range(0, len - 1);
              bits[b] = ~bits[b];
            end else if (pick < 8) begin
              len = (len == dpt_pkg::MaxSteps) ? len - 1'b1 : len + 1'b1;
            end
          end
        end
        dpt_pkg::OP_FIND_BY_ID: begin
          if (pick < 70) id = dpt_pkg::IdW'($urandom_range(1, tracker.count + 1));
        end
        default: begin
          if (pick < 70) begin
            k   = $urandom_range(0, tracker.count);
            idx = dpt_pkg::IdxW'((k > dpt_pkg::MaxEntries - 1) ?
                                 dpt_pkg::MaxEntries - 1 : k);
          end
        end
      endcase
      send_request(op, bits, len, id, idx);
      if (n % 500 == 499) wait_for_results();
    end

    if (burst_left != 0 || in_valid) begin
      @(posedge clk);
    end
    in_valid <= 1'b0;
    wait_for_results();
    repeat (2 * PassLatency) @(posedge clk);

    $display("covered %0d requests with %0d results checked, %0d entries in the table at the end",
             RandomItems + 24, tracker.checked, tracker.count);
    $display("statuses: found %0d, inserted %0d, not found %0d, invalid %0d, full %0d",
             tracker.status_seen[dpt_pkg::ST_FOUND], tracker.status_seen[dpt_pkg::ST_INSERTED],
             tracker.status_seen[dpt_pkg::ST_NOT_FOUND],
             tracker.status_seen[dpt_pkg::ST_INVALID],
             tracker.status_seen[dpt_pkg::ST_FULL]);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("[dedup_pattern_table_core] OK");
    end else begin
      $display("[dedup_pattern_table_core] ERROR");
    end
    $finish;
  end

endmodule
